// ----- src/mlfq_pkg.sv -----
// Shared constants, codes and control/status types of the MLFQ scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;

   localparam int MAX_LEVELS = 8;
   localparam int MAX_PROCS  = 16;
   localparam int LVL_W      = $clog2(MAX_LEVELS);
   localparam int SLOT_W     = $clog2(MAX_PROCS);
   localparam int ADDR_W     = LVL_W + SLOT_W;
   localparam int DEPTH      = MAX_LEVELS * MAX_PROCS;
   localparam int CNT_W      = 5;
   localparam int NL_W       = 4;
   localparam int NP_W       = 5;
   localparam int PERIOD_W   = 16;
   localparam int OC_W       = 2;
   localparam int KIND_W     = 3;
   localparam int PID_W      = 5;
   localparam int LABEL_W    = 4;
   localparam int CSR_ADDR_W = 2;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_NUM_LEVELS   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_NUM_PROCS    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_BOOST_PERIOD = 2'd2;

   localparam logic [NL_W-1:0]     NUM_LEVELS_RST   = 4'd3;
   localparam logic [NP_W-1:0]     NUM_PROCS_RST    = 5'd4;
   localparam logic [PERIOD_W-1:0] BOOST_PERIOD_RST = 16'd10;

   // operations
   localparam logic OP_START = 1'b0;
   localparam logic OP_SLICE = 1'b1;

   // outcomes (anything else is an exit)
   localparam logic [OC_W-1:0] OC_FULL  = 2'd0;
   localparam logic [OC_W-1:0] OC_YIELD = 2'd1;

   // record kinds
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_YIELD   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EXITED  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BOOSTED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_STARTED = 3'd5;

   typedef struct packed {
      logic accept_slice;  // latch outcome, read head of highest busy level
      logic load_start;    // clear all queues
      logic load_step;     // write one process id into the top level
      logic load_finish;   // set top level count, emit start record
      logic pop_apply;     // requeue/drop served process, emit record
      logic boost_read;    // read head of highest busy level below top
      logic boost_move;    // move that process to top, emit record
      logic emit_idle;     // emit idle record
   } cmd_type;

   typedef struct packed {
      logic slice_found;
      logic load_done;
      logic out_free;
      logic boost_due;
      logic below_after;
   } status_type;

endpackage
`default_nettype wire

// ----- src/mlfq_ctrl.sv -----
// Controller state machine of the MLFQ scheduler.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic                req_op,
   input  wire mlfq_pkg::status_type status,
   output mlfq_pkg::cmd_type        cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_LOAD     = 3'd1;
   localparam logic [2:0] ST_POP      = 3'd2;
   localparam logic [2:0] ST_BREAD    = 3'd3;
   localparam logic [2:0] ST_BMOVE    = 3'd4;
   localparam logic [2:0] ST_IDLE_OUT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_op == mlfq_pkg::OP_START) begin
                  cmd.load_start = 1'b1;
                  state_in       = ST_LOAD;
               end else if (status.slice_found) begin
                  cmd.accept_slice = 1'b1;
                  state_in         = ST_POP;
               end else begin
                  state_in = ST_IDLE_OUT;
               end
            end
         end
         ST_LOAD: begin
            if (!status.load_done) begin
               cmd.load_step = 1'b1;
            end else if (status.out_free) begin
               cmd.load_finish = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_POP: begin
            if (status.out_free) begin
               cmd.pop_apply = 1'b1;
               state_in = (status.boost_due && status.below_after) ? ST_BREAD : ST_IDLE;
            end
         end
         ST_BREAD: begin
            cmd.boost_read = 1'b1;
            state_in       = ST_BMOVE;
         end
         ST_BMOVE: begin
            if (status.out_free) begin
               cmd.boost_move = 1'b1;
               state_in       = status.below_after ? ST_BREAD : ST_IDLE;
            end
         end
         ST_IDLE_OUT: begin
            if (status.out_free) begin
               cmd.emit_idle = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/mlfq_dpath.sv -----
// Datapath of the MLFQ scheduler: level queues, queue store, boost counter, result register.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_dpath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mlfq_pkg::cmd_type                  cmd,
   output mlfq_pkg::status_type                    status,
   input  wire logic [mlfq_pkg::NL_W-1:0]          num_levels,
   input  wire logic [mlfq_pkg::NP_W-1:0]          num_procs,
   input  wire logic [mlfq_pkg::PERIOD_W-1:0]      boost_period,
   input  wire logic [mlfq_pkg::OC_W-1:0]          outcome,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [mlfq_pkg::KIND_W-1:0]             rsp_kind,
   output logic [mlfq_pkg::PID_W-1:0]              rsp_pid,
   output logic [mlfq_pkg::LABEL_W-1:0]            rsp_label,
   output logic                                    rsp_last
);

   function automatic logic [mlfq_pkg::SLOT_W-1:0] slot_next(
      input logic [mlfq_pkg::SLOT_W-1:0] p);
      if (p == mlfq_pkg::SLOT_W'(mlfq_pkg::MAX_PROCS - 1)) begin
         return '0;
      end
      return p + mlfq_pkg::SLOT_W'(1);
   endfunction

   logic [mlfq_pkg::SLOT_W-1:0] head_ff  [mlfq_pkg::MAX_LEVELS];
   logic [mlfq_pkg::SLOT_W-1:0] head_in  [mlfq_pkg::MAX_LEVELS];
   logic [mlfq_pkg::SLOT_W-1:0] tail_ff  [mlfq_pkg::MAX_LEVELS];
   logic [mlfq_pkg::SLOT_W-1:0] tail_in  [mlfq_pkg::MAX_LEVELS];
   logic [mlfq_pkg::CNT_W-1:0]  count_ff [mlfq_pkg::MAX_LEVELS];
   logic [mlfq_pkg::CNT_W-1:0]  count_in [mlfq_pkg::MAX_LEVELS];

   logic [mlfq_pkg::SLOT_W-1:0] store_mem [mlfq_pkg::DEPTH];
   logic [mlfq_pkg::SLOT_W-1:0] rdata_ff;

   logic [mlfq_pkg::PERIOD_W-1:0] slice_ff;
   logic [mlfq_pkg::PERIOD_W-1:0] slice_in;
   logic [mlfq_pkg::PERIOD_W:0]   slice_sum;
   logic                          boost_due;

   logic [mlfq_pkg::LVL_W-1:0] src_lv_ff;
   logic [mlfq_pkg::LVL_W-1:0] src_lv_in;
   logic [mlfq_pkg::OC_W-1:0]  outcome_ff;
   logic [mlfq_pkg::OC_W-1:0]  outcome_in;
   logic [mlfq_pkg::NP_W-1:0]  load_idx_ff;
   logic [mlfq_pkg::NP_W-1:0]  load_idx_in;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [mlfq_pkg::KIND_W-1:0]   rsp_kind_ff;
   logic [mlfq_pkg::KIND_W-1:0]   rsp_kind_in;
   logic [mlfq_pkg::PID_W-1:0]    rsp_pid_ff;
   logic [mlfq_pkg::PID_W-1:0]    rsp_pid_in;
   logic [mlfq_pkg::LABEL_W-1:0]  rsp_label_ff;
   logic [mlfq_pkg::LABEL_W-1:0]  rsp_label_in;
   logic                          rsp_last_ff;
   logic                          rsp_last_in;

   logic [mlfq_pkg::NL_W-1:0]   nl_m1;
   logic [mlfq_pkg::LVL_W-1:0]  top_lv;
   logic                        slice_hit;
   logic [mlfq_pkg::LVL_W-1:0]  slice_lv;
   logic                        below_hit;
   logic [mlfq_pkg::LVL_W-1:0]  below_lv;
   logic                        below_after;

   logic                        rd_en;
   logic [mlfq_pkg::LVL_W-1:0]  rd_lv;
   logic [mlfq_pkg::ADDR_W-1:0] rd_addr;
   logic                        wr_en;
   logic [mlfq_pkg::ADDR_W-1:0] wr_addr;
   logic [mlfq_pkg::SLOT_W-1:0] wr_data;

   logic                        pop_en;
   logic                        push_en;
   logic [mlfq_pkg::LVL_W-1:0]  push_lv;
   logic [mlfq_pkg::LVL_W-1:0]  demote_lv;
   logic [mlfq_pkg::PID_W-1:0]  pid_plus1;
   logic [mlfq_pkg::LABEL_W-1:0] src_label;
   logic [mlfq_pkg::LABEL_W-1:0] demote_label;
   logic                        emit;

   assign nl_m1  = num_levels - mlfq_pkg::NL_W'(1);
   assign top_lv = nl_m1[mlfq_pkg::LVL_W-1:0];

   // highest busy level overall and highest busy level below the top
   always_comb begin
      slice_hit = 1'b0;
      slice_lv  = '0;
      below_hit = 1'b0;
      below_lv  = '0;
      for (int lv = 0; lv < mlfq_pkg::MAX_LEVELS; lv++) begin
         if (mlfq_pkg::LVL_W'(lv) <= top_lv && count_ff[lv] != '0) begin
            slice_hit = 1'b1;
            slice_lv  = mlfq_pkg::LVL_W'(lv);
         end
         if (mlfq_pkg::LVL_W'(lv) < top_lv && count_ff[lv] != '0) begin
            below_hit = 1'b1;
            below_lv  = mlfq_pkg::LVL_W'(lv);
         end
      end
   end

   assign rd_en   = cmd.accept_slice || cmd.boost_read;
   assign rd_lv   = cmd.accept_slice ? slice_lv : below_lv;
   assign rd_addr = {rd_lv, head_ff[rd_lv]};

   assign demote_lv    = (src_lv_ff != '0) ? src_lv_ff - mlfq_pkg::LVL_W'(1) : src_lv_ff;
   assign pid_plus1    = mlfq_pkg::PID_W'(rdata_ff) + mlfq_pkg::PID_W'(1);
   assign src_label    = mlfq_pkg::LABEL_W'(src_lv_ff) + mlfq_pkg::LABEL_W'(1);
   assign demote_label = mlfq_pkg::LABEL_W'(demote_lv) + mlfq_pkg::LABEL_W'(1);

   assign pop_en = cmd.pop_apply || cmd.boost_move;

   always_comb begin
      push_en = cmd.boost_move;
      push_lv = top_lv;
      if (cmd.pop_apply) begin
         case (outcome_ff)
            mlfq_pkg::OC_FULL: begin
               push_en = 1'b1;
               push_lv = demote_lv;
            end
            mlfq_pkg::OC_YIELD: begin
               push_en = 1'b1;
               push_lv = src_lv_ff;
            end
            default: begin
               push_en = 1'b0;
            end
         endcase
      end
   end

   // queue pointer and count updates
   always_comb begin
      for (int lv = 0; lv < mlfq_pkg::MAX_LEVELS; lv++) begin
         head_in[lv]  = head_ff[lv];
         tail_in[lv]  = tail_ff[lv];
         count_in[lv] = count_ff[lv];
         if (cmd.load_start) begin
            head_in[lv]  = '0;
            tail_in[lv]  = '0;
            count_in[lv] = '0;
         end
         if (cmd.load_finish && mlfq_pkg::LVL_W'(lv) == top_lv) begin
            tail_in[lv]  = num_procs[mlfq_pkg::SLOT_W-1:0];
            count_in[lv] = mlfq_pkg::CNT_W'(num_procs);
         end
         if (pop_en && mlfq_pkg::LVL_W'(lv) == src_lv_ff) begin
            head_in[lv]  = slot_next(head_ff[lv]);
            count_in[lv] = count_in[lv] - mlfq_pkg::CNT_W'(1);
         end
         if (push_en && mlfq_pkg::LVL_W'(lv) == push_lv) begin
            tail_in[lv]  = slot_next(tail_ff[lv]);
            count_in[lv] = count_in[lv] + mlfq_pkg::CNT_W'(1);
         end
      end
   end

   // levels below the top still holding work once this update lands
   always_comb begin
      below_after = 1'b0;
      for (int lv = 0; lv < mlfq_pkg::MAX_LEVELS; lv++) begin
         if (mlfq_pkg::LVL_W'(lv) < top_lv && count_in[lv] != '0) begin
            below_after = 1'b1;
         end
      end
   end

   assign slice_sum = {1'b0, slice_ff} + (mlfq_pkg::PERIOD_W + 1)'(1);
   assign boost_due = slice_sum >= {1'b0, boost_period};

   always_comb begin
      slice_in = slice_ff;
      if (cmd.load_start) begin
         slice_in = '0;
      end else if (cmd.pop_apply) begin
         slice_in = boost_due ? '0 : slice_sum[mlfq_pkg::PERIOD_W-1:0];
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {push_lv, tail_ff[push_lv]};
      wr_data = rdata_ff;
      if (cmd.load_step) begin
         wr_en   = 1'b1;
         wr_addr = {top_lv, load_idx_ff[mlfq_pkg::SLOT_W-1:0]};
         wr_data = load_idx_ff[mlfq_pkg::SLOT_W-1:0];
      end else if (push_en) begin
         wr_en = 1'b1;
      end
   end

   assign load_idx_in = cmd.load_start ? '0 :
                        cmd.load_step  ? load_idx_ff + mlfq_pkg::NP_W'(1) : load_idx_ff;
   assign src_lv_in   = rd_en ? rd_lv : src_lv_ff;
   assign outcome_in  = cmd.accept_slice ? outcome : outcome_ff;

   // result register
   assign emit = cmd.pop_apply || cmd.boost_move || cmd.load_finish || cmd.emit_idle;

   always_comb begin
      rsp_kind_in  = rsp_kind_ff;
      rsp_pid_in   = rsp_pid_ff;
      rsp_label_in = rsp_label_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_finish) begin
         rsp_kind_in  = mlfq_pkg::KIND_STARTED;
         rsp_pid_in   = '0;
         rsp_label_in = '0;
         rsp_last_in  = 1'b1;
      end else if (cmd.emit_idle) begin
         rsp_kind_in  = mlfq_pkg::KIND_IDLE;
         rsp_pid_in   = '0;
         rsp_label_in = '0;
         rsp_last_in  = 1'b1;
      end else if (cmd.pop_apply) begin
         rsp_pid_in  = pid_plus1;
         rsp_last_in = !(boost_due && below_after);
         case (outcome_ff)
            mlfq_pkg::OC_FULL: begin
               rsp_kind_in  = mlfq_pkg::KIND_FULL;
               rsp_label_in = demote_label;
            end
            mlfq_pkg::OC_YIELD: begin
               rsp_kind_in  = mlfq_pkg::KIND_YIELD;
               rsp_label_in = src_label;
            end
            default: begin
               rsp_kind_in  = mlfq_pkg::KIND_EXITED;
               rsp_label_in = '0;
            end
         endcase
      end else if (cmd.boost_move) begin
         rsp_kind_in  = mlfq_pkg::KIND_BOOSTED;
         rsp_pid_in   = pid_plus1;
         rsp_label_in = num_levels;
         rsp_last_in  = !below_after;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int lv = 0; lv < mlfq_pkg::MAX_LEVELS; lv++) begin
            head_ff[lv]  <= '0;
            tail_ff[lv]  <= '0;
            count_ff[lv] <= '0;
         end
         slice_ff     <= '0;
         load_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int lv = 0; lv < mlfq_pkg::MAX_LEVELS; lv++) begin
            head_ff[lv]  <= head_in[lv];
            tail_ff[lv]  <= tail_in[lv];
            count_ff[lv] <= count_in[lv];
         end
         slice_ff     <= slice_in;
         load_idx_ff  <= load_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_lv_ff    <= src_lv_in;
      outcome_ff   <= outcome_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_pid_ff   <= rsp_pid_in;
      rsp_label_ff <= rsp_label_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.slice_found = slice_hit;
   assign status.load_done   = load_idx_ff == num_procs;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;
   assign status.boost_due   = boost_due;
   assign status.below_after = below_after && below_hit || below_after;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_pid    = rsp_pid_ff;
   assign rsp_label  = rsp_label_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

// ----- src/mlfq_scheduler_with_boost_core.sv -----
// Top level of the MLFQ scheduler: configuration registers, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Multi-level feedback queue scheduler with periodic priority boost. A start
// transaction clears all levels and loads process ids 1..N into the top level,
// one store write per cycle. A slice transaction does a registered read of the
// head entry of the highest busy level, then requeues or drops it and emits
// its record; an idle slice emits an idle record. When a boost is due, each
// process below the top level is moved to the top level (head read, then
// move) through the single queue store. Results leave through an output
// register, so a waiting result stalls the work only when the next record is
// ready. Configuration may be written only while no transaction is in flight.
module mlfq_scheduler_with_boost_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,  // [1:0] outcome
   input  wire logic [0:0]                         req_tuser,  // [0] operation
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [15:0]                             rsp_tdata,  // [4:0] process_id, [8:5] level_label
   output logic [mlfq_pkg::KIND_W-1:0]             rsp_tuser,  // [2:0] record_kind
   output logic                                    rsp_tlast,
   input  wire logic                               csr_we,
   input  wire logic [mlfq_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [mlfq_pkg::PERIOD_W-1:0]      csr_wdata
);

   logic [mlfq_pkg::NL_W-1:0]     num_levels_ff;
   logic [mlfq_pkg::NP_W-1:0]     num_procs_ff;
   logic [mlfq_pkg::PERIOD_W-1:0] boost_period_ff;
   logic [mlfq_pkg::NL_W-1:0]     num_levels_eff;
   logic [mlfq_pkg::NP_W-1:0]     num_procs_eff;

   mlfq_pkg::cmd_type    cmd;
   mlfq_pkg::status_type status;

   logic [mlfq_pkg::PID_W-1:0]   rsp_pid;
   logic [mlfq_pkg::LABEL_W-1:0] rsp_label;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff   <= mlfq_pkg::NUM_LEVELS_RST;
         num_procs_ff    <= mlfq_pkg::NUM_PROCS_RST;
         boost_period_ff <= mlfq_pkg::BOOST_PERIOD_RST;
      end else if (csr_we) begin
         case (csr_addr)
            mlfq_pkg::REG_NUM_LEVELS: begin
               num_levels_ff <= csr_wdata[mlfq_pkg::NL_W-1:0];
            end
            mlfq_pkg::REG_NUM_PROCS: begin
               num_procs_ff <= csr_wdata[mlfq_pkg::NP_W-1:0];
            end
            mlfq_pkg::REG_BOOST_PERIOD: begin
               boost_period_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // zero levels acts as one; counts above the build limits saturate
   assign num_levels_eff = (num_levels_ff == '0) ? mlfq_pkg::NL_W'(1) :
                           (num_levels_ff > mlfq_pkg::NL_W'(mlfq_pkg::MAX_LEVELS)) ?
                              mlfq_pkg::NL_W'(mlfq_pkg::MAX_LEVELS) : num_levels_ff;
   assign num_procs_eff  = (num_procs_ff > mlfq_pkg::NP_W'(mlfq_pkg::MAX_PROCS)) ?
                              mlfq_pkg::NP_W'(mlfq_pkg::MAX_PROCS) : num_procs_ff;

   mlfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[0]),
      .status     (status),
      .cmd        (cmd)
   );

   mlfq_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .num_levels   (num_levels_eff),
      .num_procs    (num_procs_eff),
      .boost_period (boost_period_ff),
      .outcome      (req_tdata[mlfq_pkg::OC_W-1:0]),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_kind     (rsp_tuser),
      .rsp_pid      (rsp_pid),
      .rsp_label    (rsp_label),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_label, rsp_pid};

endmodule
`default_nettype wire
